FILE: rtl/mcme_pkg.sv
// shared types, codes and widths for the midi controller message expander
// no dependencies; every other file refers to it by scoped names
package mcme_pkg;

    localparam int S_TDATA_W = 120;
    localparam int S_TUSER_W = 4;
    localparam int M_TDATA_W = 40;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 14;

    localparam int SLOTS = 6;
    localparam int SLOT_W = 3;
    localparam int QDEPTH = 2;
    localparam int QPTR_W = 1;
    localparam int QCNT_W = 2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_EXT_SYNC = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NULL_MSB = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_NULL_LSB = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PERIOD = 2'd3;

    localparam logic [13:0] PERIOD_RESET = 14'd256;
    localparam logic [13:0] PERIOD_MAX = 14'd8192;
    localparam logic [13:0] PERIOD_MIN = 14'd1;
    localparam logic [7:0] NULL_NONE = 8'hFF;
    localparam logic [13:0] BEND_BIAS = 14'd8192;

    // event kinds (status high nibble)
    localparam logic [3:0] FUNC_NOTE_OFF = 4'h8;
    localparam logic [3:0] FUNC_NOTE_ON = 4'h9;
    localparam logic [3:0] FUNC_POLY_AT = 4'hA;
    localparam logic [3:0] FUNC_CTRL = 4'hB;
    localparam logic [3:0] FUNC_PROGRAM = 4'hC;
    localparam logic [3:0] FUNC_CHAN_AT = 4'hD;
    localparam logic [3:0] FUNC_BEND = 4'hE;

    // controller number ranges
    localparam logic signed [24:0] CC_AS_BEND = 25'sh40000;
    localparam logic signed [24:0] CC_AS_PROGRAM = 25'sh40001;
    localparam logic signed [24:0] CC_PAIR_BASE = 25'sh10000;
    localparam logic signed [24:0] CC_RPN_BASE = 25'sh20000;
    localparam logic signed [24:0] CC_NRPN_BASE = 25'sh30000;
    localparam logic signed [24:0] CC_RPN14_BASE = 25'sh40000;
    localparam logic signed [24:0] CC_NRPN14_BASE = 25'sh60000;
    localparam logic signed [24:0] CC_UNKNOWN_BASE = 25'sh70000;

    // controller numbers used in bursts
    localparam logic [7:0] CC_BANK_MSB = 8'h00;
    localparam logic [7:0] CC_BANK_LSB = 8'h20;
    localparam logic [7:0] CC_DATA_MSB = 8'h06;
    localparam logic [7:0] CC_DATA_LSB = 8'h26;
    localparam logic [7:0] CC_RPN_MSB = 8'h65;
    localparam logic [7:0] CC_RPN_LSB = 8'h64;
    localparam logic [7:0] CC_NRPN_MSB = 8'h63;
    localparam logic [7:0] CC_NRPN_LSB = 8'h62;

    localparam logic [1:0] LEN_SHORT = 2'd2;
    localparam logic [1:0] LEN_LONG = 2'd3;

    typedef enum logic [2:0] {
        CLS_NOTE,
        CLS_CHAN_AT,
        CLS_BEND,
        CLS_CC7,
        CLS_CC14,
        CLS_PROG,
        CLS_PARAM
    } burst_cls_t;

    typedef struct packed {
        logic        ext_sync;
        logic [7:0]  null_msb;
        logic [7:0]  null_lsb;
        logic [13:0] period;     // already bounded to 1..8192
    } cfg_t;

    typedef struct packed {
        burst_cls_t        cls;
        logic [3:0]        func;
        logic [3:0]        chan;
        logic              nrpn;
        logic              fine;
        logic [23:0]       x;
        logic [13:0]       y;
        logic [31:0]       diff;
        logic [SLOTS-1:0]  mask;
    } burst_t;

endpackage

FILE: rtl/mcme_front.sv
// front end: configuration registers, event accept and burst classification
// depends on mcme_pkg
module mcme_front (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [mcme_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [mcme_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [mcme_pkg::S_TDATA_W-1:0]   s_axis_tdata,
    input  logic [mcme_pkg::S_TUSER_W-1:0]   s_axis_tuser,
    input  logic                             queue_full,
    output logic                             push,
    output mcme_pkg::burst_t                 push_data,
    output mcme_pkg::cfg_t                   cfg
);

    mcme_pkg::cfg_t cfg_reg;
    mcme_pkg::burst_t burst;
    logic signed [24:0] data_a;
    logic signed [24:0] data_b;
    logic [31:0] event_time;
    logic [31:0] frame_base;
    logic [13:0] period_next;

    assign data_a = s_axis_tdata[28:4];
    assign data_b = s_axis_tdata[53:29];
    assign event_time = s_axis_tdata[85:54];
    assign frame_base = s_axis_tdata[117:86];

    assign cfg_ready = 1'b1;
    assign cfg = cfg_reg;

    always_comb
    begin
        if (cfg_data == '0)
        begin
            period_next = mcme_pkg::PERIOD_MIN;
        end
        else if (cfg_data > mcme_pkg::PERIOD_MAX)
        begin
            period_next = mcme_pkg::PERIOD_MAX;
        end
        else
        begin
            period_next = cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.ext_sync <= 1'b0;
            cfg_reg.null_msb <= mcme_pkg::NULL_NONE;
            cfg_reg.null_lsb <= mcme_pkg::NULL_NONE;
            cfg_reg.period <= mcme_pkg::PERIOD_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                mcme_pkg::CFG_EXT_SYNC: cfg_reg.ext_sync <= cfg_data[0];
                mcme_pkg::CFG_NULL_MSB: cfg_reg.null_msb <= cfg_data[7:0];
                mcme_pkg::CFG_NULL_LSB: cfg_reg.null_lsb <= cfg_data[7:0];
                mcme_pkg::CFG_PERIOD:   cfg_reg.period <= period_next;
                default:                cfg_reg <= cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        burst = '0;
        burst.cls = mcme_pkg::CLS_NOTE;
        burst.func = s_axis_tuser;
        burst.chan = s_axis_tdata[3:0];
        burst.x = data_a[23:0];
        burst.y = data_b[13:0];
        // zero time or external sync means the frame base itself
        if (event_time == '0 || cfg_reg.ext_sync)
        begin
            burst.diff = '0;
        end
        else
        begin
            burst.diff = event_time - frame_base;
        end
        case (s_axis_tuser) inside
            mcme_pkg::FUNC_NOTE_OFF, mcme_pkg::FUNC_NOTE_ON, mcme_pkg::FUNC_POLY_AT:
            begin
                burst.cls = mcme_pkg::CLS_NOTE;
                burst.mask = 6'b000001;
            end
            mcme_pkg::FUNC_CHAN_AT:
            begin
                burst.cls = mcme_pkg::CLS_CHAN_AT;
                burst.mask = 6'b000001;
            end
            mcme_pkg::FUNC_BEND:
            begin
                burst.cls = mcme_pkg::CLS_BEND;
                burst.y = data_a[13:0] + mcme_pkg::BEND_BIAS;
                burst.mask = 6'b000001;
            end
            mcme_pkg::FUNC_PROGRAM:
            begin
                burst.cls = mcme_pkg::CLS_PROG;
                burst.mask = {3'b000, 1'b1, data_a[15:8] != mcme_pkg::NULL_NONE,
                              data_a[23:16] != mcme_pkg::NULL_NONE};
            end
            mcme_pkg::FUNC_CTRL:
            begin
                if (data_a == mcme_pkg::CC_AS_BEND)
                begin
                    burst.cls = mcme_pkg::CLS_BEND;
                    burst.y = data_b[13:0] + mcme_pkg::BEND_BIAS;
                    burst.mask = 6'b000001;
                end
                else if (data_a == mcme_pkg::CC_AS_PROGRAM)
                begin
                    burst.cls = mcme_pkg::CLS_PROG;
                    burst.x = data_b[23:0];
                    burst.mask = {3'b000, 1'b1, data_b[15:8] != mcme_pkg::NULL_NONE,
                                  data_b[23:16] != mcme_pkg::NULL_NONE};
                end
                else if (data_a < mcme_pkg::CC_PAIR_BASE)
                begin
                    burst.cls = mcme_pkg::CLS_CC7;
                    burst.mask = 6'b000001;
                end
                else if (data_a < mcme_pkg::CC_RPN_BASE)
                begin
                    burst.cls = mcme_pkg::CLS_CC14;
                    burst.mask = 6'b000011;
                end
                else if (data_a < mcme_pkg::CC_UNKNOWN_BASE)
                begin
                    burst.cls = mcme_pkg::CLS_PARAM;
                    burst.nrpn = (data_a >= mcme_pkg::CC_NRPN_BASE
                                  && data_a < mcme_pkg::CC_RPN14_BASE)
                                 || data_a >= mcme_pkg::CC_NRPN14_BASE;
                    burst.fine = data_a >= mcme_pkg::CC_RPN14_BASE;
                    burst.mask = {cfg_reg.null_lsb != mcme_pkg::NULL_NONE,
                                  cfg_reg.null_msb != mcme_pkg::NULL_NONE,
                                  burst.fine, 3'b111};
                end
            end
            default:
            begin
                burst.mask = '0;
            end
        endcase
    end

    assign s_axis_tready = !queue_full;
    // events that expand to nothing are taken and dropped here
    assign push = s_axis_tvalid && s_axis_tready && (burst.mask != '0);
    assign push_data = burst;

endmodule

FILE: rtl/mcme_queue.sv
// two-entry queue of burst descriptors between front and back end
// depends on mcme_pkg
module mcme_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  mcme_pkg::burst_t  push_data,
    output logic              full,
    input  logic              pop,
    output logic              head_valid,
    output mcme_pkg::burst_t  head
);

    mcme_pkg::burst_t entry_reg [mcme_pkg::QDEPTH];
    logic [mcme_pkg::QPTR_W-1:0] wr_ptr_reg;
    logic [mcme_pkg::QPTR_W-1:0] rd_ptr_reg;
    logic [mcme_pkg::QCNT_W-1:0] count_reg;
    logic [mcme_pkg::QCNT_W-1:0] count_next;

    assign full = count_reg == mcme_pkg::QCNT_W'(mcme_pkg::QDEPTH);
    assign head_valid = count_reg != '0;
    assign head = entry_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

FILE: rtl/mcme_back.sv
// back end: walks the slots of the head burst, one message per beat, into
// the output register; depends on mcme_pkg
module mcme_back (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            head_valid,
    input  mcme_pkg::burst_t                head,
    input  mcme_pkg::cfg_t                  cfg,
    output logic                            pop,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [mcme_pkg::M_TDATA_W-1:0]  m_axis_tdata,
    output logic                            m_axis_tlast
);

    logic [mcme_pkg::SLOTS-1:0] sent_reg;
    logic [mcme_pkg::SLOTS-1:0] remaining;
    logic [mcme_pkg::SLOTS-1:0] rest;
    logic [mcme_pkg::SLOT_W-1:0] idx;
    logic advance;
    logic [3:0] kind;
    logic [7:0] d1;
    logic [7:0] d2;
    logic [1:0] len;
    logic [2:0] step;
    logic [2:0] null_step;
    logic [7:0] sel_hi;
    logic [7:0] sel_lo;
    logic [31:0] offset_raw;
    logic [12:0] offset;
    logic m_tvalid_reg;
    logic [mcme_pkg::M_TDATA_W-1:0] m_tdata_reg;
    logic m_tlast_reg;

    assign remaining = head.mask & ~sent_reg;

    // lowest pending slot goes next
    always_comb
    begin
        idx = '0;
        for (int i = mcme_pkg::SLOTS - 1; i >= 0; i--)
        begin
            if (remaining[i])
            begin
                idx = mcme_pkg::SLOT_W'(i);
            end
        end
    end

    assign rest = remaining & ~(mcme_pkg::SLOTS'(1) << idx);
    assign advance = head_valid && (!m_tvalid_reg || m_axis_tready);
    assign pop = advance && (rest == '0);

    always_comb
    begin
        sel_hi = head.nrpn ? mcme_pkg::CC_NRPN_MSB : mcme_pkg::CC_RPN_MSB;
        sel_lo = head.nrpn ? mcme_pkg::CC_NRPN_LSB : mcme_pkg::CC_RPN_LSB;
        // null selection follows the data entry; lsb shifts down if msb is skipped
        null_step = head.fine ? 3'd4 : 3'd3;
        kind = mcme_pkg::FUNC_CTRL;
        d1 = head.x[7:0];
        d2 = head.y[7:0];
        len = mcme_pkg::LEN_LONG;
        step = '0;
        case (head.cls)
            mcme_pkg::CLS_NOTE:
            begin
                kind = head.func;
            end
            mcme_pkg::CLS_CHAN_AT:
            begin
                kind = mcme_pkg::FUNC_CHAN_AT;
                d2 = '0;
                len = mcme_pkg::LEN_SHORT;
            end
            mcme_pkg::CLS_BEND:
            begin
                kind = mcme_pkg::FUNC_BEND;
                d1 = {1'b0, head.y[6:0]};
                d2 = {1'b0, head.y[13:7]};
            end
            mcme_pkg::CLS_CC7:
            begin
                kind = mcme_pkg::FUNC_CTRL;
            end
            mcme_pkg::CLS_CC14:
            begin
                step = idx;
                if (idx == '0)
                begin
                    d1 = {1'b0, head.x[14:8]};
                    d2 = {1'b0, head.y[13:7]};
                end
                else
                begin
                    d1 = {1'b0, head.x[6:0]};
                    d2 = {1'b0, head.y[6:0]};
                end
            end
            mcme_pkg::CLS_PROG:
            begin
                step = idx;
                case (idx)
                    3'd0:
                    begin
                        d1 = mcme_pkg::CC_BANK_MSB;
                        d2 = head.x[23:16];
                    end
                    3'd1:
                    begin
                        d1 = mcme_pkg::CC_BANK_LSB;
                        d2 = head.x[15:8];
                    end
                    default:
                    begin
                        kind = mcme_pkg::FUNC_PROGRAM;
                        d1 = {1'b0, head.x[6:0]};
                        d2 = '0;
                        len = mcme_pkg::LEN_SHORT;
                    end
                endcase
            end
            mcme_pkg::CLS_PARAM:
            begin
                case (idx)
                    3'd0:
                    begin
                        d1 = sel_hi;
                        d2 = {1'b0, head.x[14:8]};
                        step = 3'd0;
                    end
                    3'd1:
                    begin
                        d1 = sel_lo;
                        d2 = {1'b0, head.x[6:0]};
                        step = 3'd1;
                    end
                    3'd2:
                    begin
                        d1 = mcme_pkg::CC_DATA_MSB;
                        d2 = head.fine ? {1'b0, head.y[13:7]} : head.y[7:0];
                        step = 3'd2;
                    end
                    3'd3:
                    begin
                        d1 = mcme_pkg::CC_DATA_LSB;
                        d2 = {1'b0, head.y[6:0]};
                        step = 3'd3;
                    end
                    3'd4:
                    begin
                        d1 = sel_hi;
                        d2 = {1'b0, cfg.null_msb[6:0]};
                        step = null_step;
                    end
                    default:
                    begin
                        d1 = sel_lo;
                        d2 = {1'b0, cfg.null_lsb[6:0]};
                        step = null_step + {2'b00, head.mask[4]};
                    end
                endcase
            end
            default:
            begin
                kind = head.func;
            end
        endcase
    end

    // offset within the period, clamped to zero and period minus one
    assign offset_raw = head.diff + {29'd0, step};

    always_comb
    begin
        if (offset_raw[31])
        begin
            offset = '0;
        end
        else if (offset_raw >= {18'd0, cfg.period})
        begin
            offset = 13'(cfg.period - 14'd1);
        end
        else
        begin
            offset = offset_raw[12:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sent_reg <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                sent_reg <= (rest == '0) ? '0 : (head.mask & ~rest);
                m_tvalid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            m_tdata_reg <= {1'b0, offset, len, d2, d1, kind, head.chan};
            m_tlast_reg <= rest == '0;
        end
    end

    assign m_axis_tvalid = m_tvalid_reg;
    assign m_axis_tdata = m_tdata_reg;
    assign m_axis_tlast = m_tlast_reg;

endmodule

FILE: rtl/midi_controller_message_expander_unit.sv
// the first message of an event becomes valid on the output once it is loaded into the
// output register, after the event has been written into the queue on its accepting edge;
// the back end sends one message per cycle while the sink is ready (an event expands to 1 to 6
// messages), and the front takes one event per cycle as long as the two-entry
// queue has room
// reset (rst_n low, asynchronous): queue and output emptied, registers to reset values
module midi_controller_message_expander_unit (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [mcme_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [mcme_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // channel[3:0], data_a[28:4], data_b[53:29], event_time[85:54],
    // frame_base[117:86], zero pad
    input  logic [mcme_pkg::S_TDATA_W-1:0]   s_axis_tdata,
    // func[3:0]
    input  logic [mcme_pkg::S_TUSER_W-1:0]   s_axis_tuser,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // status[7:0], data1[15:8], data2[23:16], length[25:24],
    // frame_offset[38:26], zero pad
    output logic [mcme_pkg::M_TDATA_W-1:0]   m_axis_tdata,
    output logic                             m_axis_tlast
);

    mcme_pkg::cfg_t cfg;
    mcme_pkg::burst_t push_data;
    mcme_pkg::burst_t head;
    logic push;
    logic pop;
    logic queue_full;
    logic head_valid;

    mcme_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .queue_full    (queue_full),
        .push          (push),
        .push_data     (push_data),
        .cfg           (cfg)
    );

    mcme_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_data  (push_data),
        .full       (queue_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head       (head)
    );

    mcme_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .head_valid    (head_valid),
        .head          (head),
        .cfg           (cfg),
        .pop           (pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

FILE: rtl/mcme_checker.sv
// port-level checks on the message expander output stream, bound to the top level
// depends on mcme_pkg and midi_controller_message_expander_unit
module mcme_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    input  logic [mcme_pkg::M_TDATA_W-1:0]  m_axis_tdata,
    input  logic                            m_axis_tlast
);

    // a stalled beat holds
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
        m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("output beat changed while stalled");

    // every message is two or three bytes, and a short one has no second data byte
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |->
        (m_axis_tdata[25:24] == mcme_pkg::LEN_LONG)
        || (m_axis_tdata[25:24] == mcme_pkg::LEN_SHORT && m_axis_tdata[23:16] == 8'd0))
        else $error("bad message length or data2");

    // status byte always has its top bit set
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[7])
        else $error("status byte without status bit");

    // bend and program bytes are 7-bit
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tdata[7:4] == mcme_pkg::FUNC_BEND
                          || m_axis_tdata[7:4] == mcme_pkg::FUNC_PROGRAM)
        |-> !m_axis_tdata[15] && !m_axis_tdata[23])
        else $error("bend or program data byte above 127");

endmodule

bind midi_controller_message_expander_unit mcme_checker u_mcme_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);

FILE: verif/tb_midi_controller_message_expander_unit.sv
// testbench for midi_controller_message_expander_unit: directed and random events,
// each expanded into its expected burst of midi messages and checked beat by beat
// depends on rtl/mcme_pkg.sv and rtl/midi_controller_message_expander_unit.sv
module tb_midi_controller_message_expander_unit;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [3:0]         func;
        logic [3:0]         chan;
        logic signed [24:0] data_a;
        logic signed [24:0] data_b;
        logic [31:0]        event_time;
        logic [31:0]        frame_base;
    } midi_event_t;

    typedef struct packed {
        logic [7:0]  status;
        logic [7:0]  data1;
        logic [7:0]  data2;
        logic [1:0]  length;
        logic [12:0] offset;
        logic        last;
    } midi_msg_t;

    logic                            clk;
    logic                            rst_n;
    logic                            cfg_valid;
    logic                            cfg_ready;
    logic [mcme_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [mcme_pkg::CFG_DATA_W-1:0] cfg_data;
    logic                            s_axis_tvalid;
    logic                            s_axis_tready;
    logic [mcme_pkg::S_TDATA_W-1:0]  s_axis_tdata;
    logic [mcme_pkg::S_TUSER_W-1:0]  s_axis_tuser;
    logic                            m_axis_tvalid;
    logic                            m_axis_tready;
    logic [mcme_pkg::M_TDATA_W-1:0]  m_axis_tdata;
    logic                            m_axis_tlast;

    // register copies as the block should hold them
    logic        reg_ext_sync = 1'b0;
    logic [7:0]  reg_null_msb = mcme_pkg::NULL_NONE;
    logic [7:0]  reg_null_lsb = mcme_pkg::NULL_NONE;
    logic [13:0] reg_period = mcme_pkg::PERIOD_RESET;

    midi_msg_t   expected_msgs[$];
    midi_msg_t   burst[$];
    logic [3:0]  burst_chan;
    logic [31:0] burst_time;
    logic [31:0] burst_base;
    int          error_count = 0;
    logic        idle_on = 1'b0;

    midi_controller_message_expander_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ---------------------------------------------------------------- burst predictor

    function automatic logic [13:0] eff_period();
        logic [13:0] p;
        p = reg_period;
        if (p == 14'd0)
            p = mcme_pkg::PERIOD_MIN;
        if (p > mcme_pkg::PERIOD_MAX)
            p = mcme_pkg::PERIOD_MAX;
        return p;
    endfunction

    function automatic logic [12:0] frame_offset_of(logic [31:0] tm);
        logic [31:0] d;
        logic [13:0] p;
        d = tm - burst_base;
        p = eff_period();
        if (d[31])
            return 13'd0;
        if (d >= 32'(p))
            return 13'(p - 14'd1);
        return d[12:0];
    endfunction

    function automatic void add_msg(logic [3:0] kind, logic [31:0] d1, logic [31:0] d2,
                                    logic [1:0] len, int step);
        midi_msg_t m;
        m.status = {kind, burst_chan};
        m.data1  = d1[7:0];
        m.data2  = (len == mcme_pkg::LEN_LONG) ? d2[7:0] : 8'd0;
        m.length = len;
        m.offset = frame_offset_of(burst_time + 32'(step));
        m.last   = 1'b0;
        burst.push_back(m);
    endfunction

    function automatic void add_program(logic [31:0] w);
        if (w[23:16] != mcme_pkg::NULL_NONE)
            add_msg(mcme_pkg::FUNC_CTRL, mcme_pkg::CC_BANK_MSB, w[23:16],
                    mcme_pkg::LEN_LONG, 0);
        if (w[15:8] != mcme_pkg::NULL_NONE)
            add_msg(mcme_pkg::FUNC_CTRL, mcme_pkg::CC_BANK_LSB, w[15:8],
                    mcme_pkg::LEN_LONG, 1);
        add_msg(mcme_pkg::FUNC_PROGRAM, w & 32'h7F, 32'd0, mcme_pkg::LEN_SHORT, 2);
    endfunction

    function automatic void add_bend(logic [31:0] w);
        logic [31:0] v;
        v = w + 32'(mcme_pkg::BEND_BIAS);
        add_msg(mcme_pkg::FUNC_BEND, v & 32'h7F, (v >> 7) & 32'h7F, mcme_pkg::LEN_LONG, 0);
    endfunction

    function automatic void add_param(logic [31:0] a, logic [31:0] b, logic nrpn, logic fine);
        logic [7:0] sel_hi;
        logic [7:0] sel_lo;
        int step;
        sel_hi = nrpn ? mcme_pkg::CC_NRPN_MSB : mcme_pkg::CC_RPN_MSB;
        sel_lo = nrpn ? mcme_pkg::CC_NRPN_LSB : mcme_pkg::CC_RPN_LSB;
        add_msg(mcme_pkg::FUNC_CTRL, sel_hi, (a >> 8) & 32'h7F, mcme_pkg::LEN_LONG, 0);
        add_msg(mcme_pkg::FUNC_CTRL, sel_lo, a & 32'h7F, mcme_pkg::LEN_LONG, 1);
        if (fine)
        begin
            add_msg(mcme_pkg::FUNC_CTRL, mcme_pkg::CC_DATA_MSB, (b >> 7) & 32'h7F,
                    mcme_pkg::LEN_LONG, 2);
            add_msg(mcme_pkg::FUNC_CTRL, mcme_pkg::CC_DATA_LSB, b & 32'h7F,
                    mcme_pkg::LEN_LONG, 3);
            step = 4;
        end
        else
        begin
            // coarse data keeps all eight low bits
            add_msg(mcme_pkg::FUNC_CTRL, mcme_pkg::CC_DATA_MSB, b, mcme_pkg::LEN_LONG, 2);
            step = 3;
        end
        if (reg_null_msb != mcme_pkg::NULL_NONE)
        begin
            add_msg(mcme_pkg::FUNC_CTRL, sel_hi, reg_null_msb & 8'h7F, mcme_pkg::LEN_LONG, step);
            step++;
        end
        if (reg_null_lsb != mcme_pkg::NULL_NONE)
            add_msg(mcme_pkg::FUNC_CTRL, sel_lo, reg_null_lsb & 8'h7F, mcme_pkg::LEN_LONG, step);
    endfunction

    function automatic void add_controller(logic signed [31:0] a, logic signed [31:0] b);
        if (a == mcme_pkg::CC_AS_BEND)
            add_bend(b);
        else if (a == mcme_pkg::CC_AS_PROGRAM)
            add_program(b);
        else if (a < mcme_pkg::CC_PAIR_BASE)
            add_msg(mcme_pkg::FUNC_CTRL, a, b, mcme_pkg::LEN_LONG, 0);
        else if (a < mcme_pkg::CC_RPN_BASE)
        begin
            add_msg(mcme_pkg::FUNC_CTRL, (a >> 8) & 32'h7F, (b >> 7) & 32'h7F,
                    mcme_pkg::LEN_LONG, 0);
            add_msg(mcme_pkg::FUNC_CTRL, a & 32'h7F, b & 32'h7F, mcme_pkg::LEN_LONG, 1);
        end
        else if (a < mcme_pkg::CC_NRPN_BASE)
            add_param(a, b, 1'b0, 1'b0);
        else if (a < mcme_pkg::CC_RPN14_BASE)
            add_param(a, b, 1'b1, 1'b0);
        else if (a < mcme_pkg::CC_NRPN14_BASE)
            add_param(a, b, 1'b0, 1'b1);
        else if (a < mcme_pkg::CC_UNKNOWN_BASE)
            add_param(a, b, 1'b1, 1'b1);
    endfunction

    function automatic void expand_event(midi_event_t ev);
        logic signed [31:0] a;
        logic signed [31:0] b;
        midi_msg_t tail;
        burst.delete();
        a = ev.data_a;
        b = ev.data_b;
        burst_chan = ev.chan;
        burst_base = ev.frame_base;
        burst_time = (ev.event_time == 32'd0 || reg_ext_sync) ? ev.frame_base : ev.event_time;
        case (ev.func)
            mcme_pkg::FUNC_NOTE_OFF, mcme_pkg::FUNC_NOTE_ON, mcme_pkg::FUNC_POLY_AT:
                add_msg(ev.func, a, b, mcme_pkg::LEN_LONG, 0);
            mcme_pkg::FUNC_CTRL:    add_controller(a, b);
            mcme_pkg::FUNC_PROGRAM: add_program(a);
            mcme_pkg::FUNC_CHAN_AT:
                add_msg(mcme_pkg::FUNC_CHAN_AT, a, 32'd0, mcme_pkg::LEN_SHORT, 0);
            mcme_pkg::FUNC_BEND:    add_bend(a);
            default: ;
        endcase
        if (burst.size() > 0)
        begin
            tail = burst.pop_back();
            tail.last = 1'b1;
            burst.push_back(tail);
        end
        foreach (burst[i])
            expected_msgs.push_back(burst[i]);
    endfunction

    // ---------------------------------------------------------------- drivers

    function automatic int pick_gap(int long_lo, int long_hi);
        int r;
        if (!idle_on)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(long_lo, long_hi);
    endfunction

    task automatic send_event(midi_event_t ev);
        int gap;
        gap = pick_gap(8, 30);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tdata  <= {2'b00, ev.frame_base, ev.event_time, ev.data_b, ev.data_a, ev.chan};
        s_axis_tuser  <= ev.func;
        s_axis_tvalid <= 1'b1;
        do @(negedge clk); while (!s_axis_tready);
        @(posedge clk);
        expand_event(ev);
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (expected_msgs.size() != 0)
            @(posedge clk);
        // events with an empty burst may still be in flight
        repeat (10) @(posedge clk);
    endtask

    task automatic write_reg(logic [mcme_pkg::CFG_IDX_W-1:0] idx,
                             logic [mcme_pkg::CFG_DATA_W-1:0] value);
        cfg_index <= idx;
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        do @(negedge clk); while (!cfg_ready);
        @(posedge clk);
        cfg_valid <= 1'b0;
        case (idx)
            mcme_pkg::CFG_EXT_SYNC: reg_ext_sync = value[0];
            mcme_pkg::CFG_NULL_MSB: reg_null_msb = value[7:0];
            mcme_pkg::CFG_NULL_LSB: reg_null_lsb = value[7:0];
            mcme_pkg::CFG_PERIOD:   reg_period = value;
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic set_config(logic ext, logic [7:0] nmsb, logic [7:0] nlsb, logic [13:0] per);
        drain_results();
        write_reg(mcme_pkg::CFG_EXT_SYNC, 14'(ext));
        write_reg(mcme_pkg::CFG_NULL_MSB, 14'(nmsb));
        write_reg(mcme_pkg::CFG_NULL_LSB, 14'(nlsb));
        write_reg(mcme_pkg::CFG_PERIOD, per);
    endtask

    function automatic midi_event_t make_event(logic [3:0] func, logic [3:0] chan,
                                               logic signed [24:0] a, logic signed [24:0] b,
                                               logic [31:0] tm, logic [31:0] base);
        midi_event_t ev;
        ev.func = func;
        ev.chan = chan;
        ev.data_a = a;
        ev.data_b = b;
        ev.event_time = tm;
        ev.frame_base = base;
        return ev;
    endfunction

    // ---------------------------------------------------------------- random items

    function automatic logic signed [24:0] random_value();
        int r;
        r = $urandom_range(0, 99);
        if (r < 30)
            return 25'($urandom_range(0, 127));
        if (r < 50)
            return 25'($urandom_range(0, 16383));
        if (r < 80)
            return 25'($urandom_range(0, 24'hFFFFFF));
        return 25'(-int'($urandom_range(1, 8192)));
    endfunction

    function automatic logic signed [24:0] random_controller();
        case ($urandom_range(0, 9))
            0: return 25'(-int'($urandom_range(1, 8192)));
            1: return 25'($urandom_range(0, 127));
            2: return 25'($urandom_range(0, 16'hFFFF));
            3: return mcme_pkg::CC_PAIR_BASE + 25'($urandom_range(0, 16'hFFFF));
            4: return mcme_pkg::CC_RPN_BASE + 25'($urandom_range(0, 16'hFFFF));
            5: return mcme_pkg::CC_NRPN_BASE + 25'($urandom_range(0, 16'hFFFF));
            6: return ($urandom_range(0, 1) == 1) ? mcme_pkg::CC_AS_BEND
                                                   : mcme_pkg::CC_AS_PROGRAM;
            7: return mcme_pkg::CC_RPN14_BASE + 25'($urandom_range(2, 20'h1FFFF));
            8: return mcme_pkg::CC_NRPN14_BASE + 25'($urandom_range(0, 16'hFFFF));
            default: return 25'($urandom_range(32'(mcme_pkg::CC_UNKNOWN_BASE), 24'hFFFFFF));
        endcase
    endfunction

    function automatic midi_event_t random_event();
        midi_event_t ev;
        int r;
        int delta;
        r = $urandom_range(0, 99);
        if (r < 8)
            ev.func = 4'($urandom_range(0, 7));
        else if (r < 10)
            ev.func = mcme_pkg::FUNC_BEND + 4'd1;     // unused kind above pitchbend
        else if (r < 20)
            ev.func = mcme_pkg::FUNC_NOTE_OFF;
        else if (r < 32)
            ev.func = mcme_pkg::FUNC_NOTE_ON;
        else if (r < 40)
            ev.func = mcme_pkg::FUNC_POLY_AT;
        else if (r < 70)
            ev.func = mcme_pkg::FUNC_CTRL;
        else if (r < 80)
            ev.func = mcme_pkg::FUNC_PROGRAM;
        else if (r < 88)
            ev.func = mcme_pkg::FUNC_CHAN_AT;
        else
            ev.func = mcme_pkg::FUNC_BEND;
        ev.chan = 4'($urandom_range(0, 15));
        ev.data_a = (ev.func == mcme_pkg::FUNC_CTRL) ? random_controller() : random_value();
        ev.data_b = random_value();
        // bank bytes of all ones suppress the bank-select beats
        if (ev.func == mcme_pkg::FUNC_PROGRAM)
        begin
            if ($urandom_range(0, 2) == 0)
                ev.data_a[23:16] = mcme_pkg::NULL_NONE;
            if ($urandom_range(0, 2) == 0)
                ev.data_a[15:8] = mcme_pkg::NULL_NONE;
        end
        else if (ev.func == mcme_pkg::FUNC_CTRL && ev.data_a == mcme_pkg::CC_AS_PROGRAM)
        begin
            if ($urandom_range(0, 2) == 0)
                ev.data_b[23:16] = mcme_pkg::NULL_NONE;
            if ($urandom_range(0, 2) == 0)
                ev.data_b[15:8] = mcme_pkg::NULL_NONE;
        end
        ev.frame_base = $urandom();
        r = $urandom_range(0, 99);
        if (r < 20)
            ev.event_time = 32'd0;
        else if (r < 75)
        begin
            delta = $urandom_range(0, 32'(eff_period()) + 40) - 20;
            ev.event_time = ev.frame_base + 32'(delta);
        end
        else
            ev.event_time = $urandom();
        return ev;
    endfunction

    // ---------------------------------------------------------------- tests

    task automatic test_channel_messages();
        idle_on = 1'b0;
        send_event(make_event(mcme_pkg::FUNC_NOTE_OFF, 4'd0, 25'sd0, 25'sd0, 32'd0, 32'd0));
        send_event(make_event(mcme_pkg::FUNC_NOTE_ON, 4'd15, -25'sd8192, 25'sd16777215,
                              32'd100, 32'd90));
        send_event(make_event(mcme_pkg::FUNC_POLY_AT, 4'd5, 25'sh3C, 25'sh7F, 32'd7, 32'd7));
        send_event(make_event(mcme_pkg::FUNC_CHAN_AT, 4'd9, 25'sh55, 25'sh1234,
                              32'd0, 32'd40));
        // kinds with no messages
        send_event(make_event(4'd0, 4'd3, 25'sd1, 25'sd2, 32'd0, 32'd0));
        send_event(make_event(mcme_pkg::FUNC_BEND + 4'd1, 4'd3, 25'sd1, 25'sd2, 32'd0, 32'd0));
    endtask

    task automatic test_program_and_bend();
        idle_on = 1'b1;
        send_event(make_event(mcme_pkg::FUNC_PROGRAM, 4'd2, 25'sh123456, 25'sd0,
                              32'd50, 32'd48));
        send_event(make_event(mcme_pkg::FUNC_PROGRAM, 4'd2, 25'shFFFF05, 25'sd0,
                              32'd0, 32'd1));
        send_event(make_event(mcme_pkg::FUNC_BEND, 4'd1, -25'sd8192, 25'sd0, 32'd0, 32'd9));
        send_event(make_event(mcme_pkg::FUNC_BEND, 4'd1, 25'sd8191, 25'sd0, 32'd0, 32'd9));
        send_event(make_event(mcme_pkg::FUNC_CTRL, 4'd6, mcme_pkg::CC_AS_BEND, 25'sd0,
                              32'd3, 32'd0));
        send_event(make_event(mcme_pkg::FUNC_CTRL, 4'd6, mcme_pkg::CC_AS_PROGRAM, 25'sh0102FF,
                              32'd3, 32'd0));
    endtask

    task automatic test_controllers();
        idle_on = 1'b1;
        send_event(make_event(mcme_pkg::FUNC_CTRL, 4'd0, 25'sd7, 25'sd100, 32'd0, 32'd5));
        send_event(make_event(mcme_pkg::FUNC_CTRL, 4'd0, -25'sd1, -25'sd1, 32'd0, 32'd5));
        send_event(make_event(mcme_pkg::FUNC_CTRL, 4'd4, mcme_pkg::CC_PAIR_BASE + 25'sh1234,
                              25'sh3FFF, 32'd0, 32'd5));
        send_event(make_event(mcme_pkg::FUNC_CTRL, 4'd4, mcme_pkg::CC_RPN_BASE + 25'shABCD,
                              25'shFF, 32'd0, 32'd5));
        send_event(make_event(mcme_pkg::FUNC_CTRL, 4'd4, mcme_pkg::CC_NRPN_BASE + 25'shFFFF,
                              25'sh80, 32'd0, 32'd5));
        // null selection in use: the fine forms reach six beats
        set_config(1'b0, 8'h80, 8'h7F, mcme_pkg::PERIOD_RESET);
        send_event(make_event(mcme_pkg::FUNC_CTRL, 4'd8, mcme_pkg::CC_RPN14_BASE + 25'sd2,
                              25'sh3FFF, 32'd0, 32'd5));
        send_event(make_event(mcme_pkg::FUNC_CTRL, 4'd8, mcme_pkg::CC_NRPN14_BASE + 25'shFFFF,
                              25'sh2AAA, 32'd0, 32'd5));
        send_event(make_event(mcme_pkg::FUNC_CTRL, 4'd8, mcme_pkg::CC_UNKNOWN_BASE, 25'sd1,
                              32'd0, 32'd5));
        send_event(make_event(mcme_pkg::FUNC_CTRL, 4'd8, 25'shFFFFFF, 25'sd1, 32'd0, 32'd5));
    endtask

    task automatic test_time_offsets();
        idle_on = 1'b1;
        set_config(1'b0, mcme_pkg::NULL_NONE, mcme_pkg::NULL_NONE, 14'd16);
        send_event(make_event(mcme_pkg::FUNC_NOTE_ON, 4'd1, 25'sd60, 25'sd64,
                              32'd995, 32'd1000));
        // time wraps past zero and the later beats clamp at period minus one
        send_event(make_event(mcme_pkg::FUNC_CTRL, 4'd1, mcme_pkg::CC_NRPN14_BASE + 25'sd3,
                              25'sd9, 32'd5, 32'hFFFFFFF8));
        send_event(make_event(mcme_pkg::FUNC_PROGRAM, 4'd1, 25'sh010203, 25'sd0,
                              32'd2000, 32'd1000));
        set_config(1'b1, mcme_pkg::NULL_NONE, mcme_pkg::NULL_NONE, 14'd0);
        send_event(make_event(mcme_pkg::FUNC_PROGRAM, 4'd1, 25'sh010203, 25'sd0,
                              32'd777, 32'd500));
        set_config(1'b0, mcme_pkg::NULL_NONE, mcme_pkg::NULL_NONE, 14'h3FFF);
        send_event(make_event(mcme_pkg::FUNC_NOTE_OFF, 4'd1, 25'sd1, 25'sd2,
                              32'd9300, 32'd300));
    endtask

    task automatic run_random_phase(int count);
        for (int i = 0; i < count; i++)
            send_event(random_event());
    endtask

    task automatic test_random_traffic();
        set_config(1'b0, mcme_pkg::NULL_NONE, mcme_pkg::NULL_NONE, mcme_pkg::PERIOD_RESET);
        idle_on = 1'b1;
        run_random_phase(17);
        set_config(1'b0, 8'h00, 8'hFE, mcme_pkg::PERIOD_MAX);
        idle_on = 1'b0;
        run_random_phase(17);
        set_config(1'b1, 8'h7F, 8'h00, 14'd16);
        idle_on = 1'b1;
        run_random_phase(17);
        set_config(1'b0, 8'hAB, mcme_pkg::NULL_NONE, 14'h3FFF);
        run_random_phase(17);
        set_config(1'b0, mcme_pkg::NULL_NONE, 8'h55, 14'd1000);
        run_random_phase(17);
    endtask

    // ---------------------------------------------------------------- sink side

    function automatic void report_field(string name, logic [31:0] want, logic [31:0] seen);
        $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, seen);
        error_count++;
    endfunction

    initial
    begin
        int hold;
        int r;
        hold = 0;
        m_axis_tready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (!idle_on)
            begin
                m_axis_tready <= 1'b1;
                hold = 0;
            end
            else if (hold > 0)
                hold--;
            else
            begin
                r = $urandom_range(0, 99);
                if (r < 65)
                begin
                    m_axis_tready <= 1'b1;
                    hold = $urandom_range(0, 7);
                end
                else
                begin
                    m_axis_tready <= 1'b0;
                    hold = (r < 93) ? $urandom_range(0, 2) : $urandom_range(9, 39);
                end
            end
        end
    end

    // outputs settle between edges, so the beat is sampled on the falling edge before it
    initial
    begin
        midi_msg_t want;
        midi_msg_t got;
        forever
        begin
            @(negedge clk);
            if (rst_n && m_axis_tvalid && m_axis_tready)
            begin
                got.status = m_axis_tdata[7:0];
                got.data1  = m_axis_tdata[15:8];
                got.data2  = m_axis_tdata[23:16];
                got.length = m_axis_tdata[25:24];
                got.offset = m_axis_tdata[38:26];
                got.last   = m_axis_tlast;
                if (expected_msgs.size() == 0)
                begin
                    $display("%0t: beat with nothing expected, got %h last %b",
                             $time, m_axis_tdata, m_axis_tlast);
                    error_count++;
                end
                else
                begin
                    want = expected_msgs.pop_front();
                    if (got.status !== want.status)
                        report_field("status", want.status, got.status);
                    if (got.data1 !== want.data1)
                        report_field("data1", want.data1, got.data1);
                    if (got.data2 !== want.data2)
                        report_field("data2", want.data2, got.data2);
                    if (got.length !== want.length)
                        report_field("length", want.length, got.length);
                    if (got.offset !== want.offset)
                        report_field("frame_offset", want.offset, got.offset);
                    if (got.last !== want.last)
                        report_field("last", want.last, got.last);
                end
            end
        end
    end

    // ---------------------------------------------------------------- sequence

    initial
    begin
        rst_n         <= 1'b0;
        cfg_valid     <= 1'b0;
        cfg_index     <= mcme_pkg::CFG_EXT_SYNC;
        cfg_data      <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_channel_messages();
        test_program_and_bend();
        test_controllers();
        test_time_offsets();
        test_random_traffic();
        s_axis_tvalid <= 1'b0;
        for (int i = 0; i < 20000 && expected_msgs.size() != 0; i++)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (error_count == 0 && expected_msgs.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial
    begin
        #5ms;
        $display("Some tests failed");
        $finish;
    end

endmodule
